// ----- hw/rtl/sfe_pkg.sv -----
// sfe_pkg: shared widths, types, register indexes and saturation helper
// for the stereo feedback echo unit; used by every file in hw/rtl
`timescale 1ns / 1ps
`default_nettype none

package sfe_pkg;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W = 16;
  localparam int GAIN_FRAC = 15;
  localparam int DELAY_W = 17;
  localparam int CFG_W = 17;
  localparam int CFG_IDX_W = 2;

  // echo store depth, a power of two
  localparam int STORE_DEPTH = 131072;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int WIDE_W = (ADDR_W > DELAY_W) ? ADDR_W : DELAY_W;

  localparam int PROD_W = SAMPLE_W + GAIN_W;
  localparam int FB_W = PROD_W - GAIN_FRAC;
  localparam int SUM_W = FB_W + 1;

  // output queue
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);
  localparam int PEND_W = FQ_CNT_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_ECHO_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_SAMPLES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [GAIN_W-1:0] gain_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;
  localparam sample_t SAMPLE_MIN = 24'sh800000;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } frame_t;

  // per-cycle control shared by both lanes
  typedef struct packed {
    logic  take;
    addr_t rd_addr;
    logic  s1_en;
    logic  fwd_s2;
    logic  fwd_lw;
    logic  s1_zero;
    logic  wr_en;
    addr_t wr_addr;
  } lane_ctl_t;

  function automatic sample_t sat_sample(input logic signed [SUM_W-1:0] v);
    sample_t res;
    if (!v[SUM_W-1] && (|v[SUM_W-2:SAMPLE_W-1])) begin
      res = SAMPLE_MAX;
    end else if (v[SUM_W-1] && !(&v[SUM_W-2:SAMPLE_W-1])) begin
      res = SAMPLE_MIN;
    end else begin
      res = v[SAMPLE_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/stereo_feedback_echo_unit.sv -----
// stereo_feedback_echo_unit: top level with config registers, write pointer,
// hazard control, two channel lanes and the output queue
// depends on sfe_pkg, sfe_lane, sfe_out_queue
//
// usage:
//   input channel: in_valid / in_stall carry one stereo frame (left_in,
//   right_in) per beat. output channel: out_valid / out_stall carry the
//   echoed frame (left_out, right_out), one per input beat, in order.
//   config: cfg_write with cfg_index and cfg_data writes echo_enable,
//   delay_samples or feedback_gain; write only while the block is idle.
//   throughput: one frame per cycle while in_stall is low, set by the single
//   read and single write per lane memory per frame and by the one-frame
//   feedback path (bypass, multiply, registered product, saturating add).
//   path: an accepted frame is registered in stage 1, then queued and offered.
//   reset: rst (synchronous) clears registers, pointer and queue; the echo
//   store is not swept, a wrap flag makes never-written entries read as
//   zero, so frames are accepted right after reset.
//   stall: results wait in a four-beat queue; in_stall rises only when the
//   queue plus frames in flight would overflow it.
`timescale 1ns / 1ps
`default_nettype none

module stereo_feedback_echo_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire sfe_pkg::sample_t                left_in,
  input  wire sfe_pkg::sample_t                right_in,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output sfe_pkg::sample_t                     left_out,
  output sfe_pkg::sample_t                     right_out,
  input  wire logic                            cfg_write,
  input  wire logic [sfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sfe_pkg::CFG_W-1:0]       cfg_data
);

  logic echo_enable;
  logic [sfe_pkg::DELAY_W-1:0] delay_samples;
  sfe_pkg::gain_t feedback_gain;

  sfe_pkg::addr_t write_pointer;
  logic wrapped;

  logic s1_valid;
  logic s1_en;
  logic s1_written;
  sfe_pkg::addr_t s1_rp;
  sfe_pkg::addr_t s1_wp;
  logic s2_write;
  sfe_pkg::addr_t s2_wp;
  logic lw_valid;
  sfe_pkg::addr_t lw_addr;

  logic accept;
  logic [sfe_pkg::WIDE_W-1:0] delay_wide;
  sfe_pkg::addr_t d_mod;
  sfe_pkg::addr_t rp;
  logic written_now;
  logic [sfe_pkg::FQ_CNT_W-1:0] q_count;
  logic [sfe_pkg::PEND_W-1:0] pending;
  sfe_pkg::lane_ctl_t ctl;
  sfe_pkg::sample_t left_res;
  sfe_pkg::sample_t right_res;

  assign pending = {1'b0, q_count} + {{sfe_pkg::FQ_CNT_W{1'b0}}, s1_valid};
  assign in_stall = (pending >= sfe_pkg::PEND_W'(sfe_pkg::FQ_DEPTH));
  assign accept = in_valid && !in_stall;

  assign delay_wide = sfe_pkg::WIDE_W'(delay_samples);
  assign d_mod = delay_wide[sfe_pkg::ADDR_W-1:0];
  assign rp = write_pointer - d_mod;
  assign written_now = wrapped || (rp < write_pointer);

  always_comb begin
    ctl.take = accept;
    ctl.rd_addr = rp;
    ctl.s1_en = s1_en;
    ctl.fwd_s2 = s2_write && (s2_wp == s1_rp);
    ctl.fwd_lw = lw_valid && (lw_addr == s1_rp);
    ctl.s1_zero = !s1_written;
    ctl.wr_en = s2_write;
    ctl.wr_addr = s2_wp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_enable <= 1'b0;
      delay_samples <= '0;
      feedback_gain <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sfe_pkg::REG_ECHO_ENABLE: echo_enable <= cfg_data[0];
        sfe_pkg::REG_DELAY_SAMPLES: delay_samples <= cfg_data[sfe_pkg::DELAY_W-1:0];
        sfe_pkg::REG_FEEDBACK_GAIN: feedback_gain <= cfg_data[sfe_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      wrapped <= 1'b0;
      s1_valid <= 1'b0;
      s2_write <= 1'b0;
      lw_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_write <= s1_valid && s1_en;
      lw_valid <= s2_write;
      if (accept && echo_enable) begin
        write_pointer <= write_pointer + 1'b1;
        if (write_pointer == '1) begin
          wrapped <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_en <= echo_enable;
      s1_rp <= rp;
      s1_wp <= write_pointer;
      s1_written <= written_now;
    end
    s2_wp <= s1_wp;
    lw_addr <= s2_wp;
  end

  sfe_lane u_lane_left (
    .clk        (clk),
    .ctl        (ctl),
    .gain       (feedback_gain),
    .sample_in  (left_in),
    .sample_out (left_res)
  );

  sfe_lane u_lane_right (
    .clk        (clk),
    .ctl        (ctl),
    .gain       (feedback_gain),
    .sample_in  (right_in),
    .sample_out (right_res)
  );

  sfe_out_queue u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (s1_valid),
    .push_left  (left_res),
    .push_right (right_res),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .left_out   (left_out),
    .right_out  (right_out),
    .count      (q_count)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/sfe_lane.sv -----
// sfe_lane: one channel of the echo, with its delay store, bypass mux,
// feedback multiply and saturating sums; depends on sfe_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfe_lane (
  input  wire logic              clk,
  input  wire sfe_pkg::lane_ctl_t ctl,
  input  wire sfe_pkg::gain_t    gain,
  input  wire sfe_pkg::sample_t  sample_in,
  output sfe_pkg::sample_t       sample_out
);

  sfe_pkg::sample_t echo_mem [sfe_pkg::STORE_DEPTH];

  sfe_pkg::sample_t rd_data;
  sfe_pkg::sample_t s1_sample;
  sfe_pkg::sample_t s2_sample;
  logic signed [sfe_pkg::PROD_W-1:0] s2_prod;
  sfe_pkg::sample_t lw_data;

  sfe_pkg::sample_t delayed;
  logic signed [sfe_pkg::PROD_W-1:0] prod;
  logic signed [sfe_pkg::FB_W-1:0] fb;
  sfe_pkg::sample_t s2_store;

  always_comb begin
    if (ctl.fwd_s2) begin
      delayed = s2_store;
    end else if (ctl.fwd_lw) begin
      delayed = lw_data;
    end else if (ctl.s1_zero) begin
      delayed = '0;
    end else begin
      delayed = rd_data;
    end
  end

  assign prod = delayed * gain;

  assign sample_out = ctl.s1_en
      ? sfe_pkg::sat_sample(sfe_pkg::SUM_W'(s1_sample) + sfe_pkg::SUM_W'(delayed))
      : s1_sample;

  assign fb = s2_prod[sfe_pkg::PROD_W-1:sfe_pkg::GAIN_FRAC];
  assign s2_store = sfe_pkg::sat_sample(sfe_pkg::SUM_W'(s2_sample) + sfe_pkg::SUM_W'(fb));

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      rd_data <= echo_mem[ctl.rd_addr];
      s1_sample <= sample_in;
    end
    if (ctl.wr_en) begin
      echo_mem[ctl.wr_addr] <= s2_store;
    end
  end

  always_ff @(posedge clk) begin
    s2_sample <= s1_sample;
    s2_prod <= prod;
    lw_data <= s2_store;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sfe_out_queue.sv -----
// sfe_out_queue: merges the two lane results into one output beat and
// buffers beats while the receiver stalls; depends on sfe_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfe_out_queue (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire sfe_pkg::sample_t              push_left,
  input  wire sfe_pkg::sample_t              push_right,
  input  wire logic                          out_stall,
  output logic                               out_valid,
  output sfe_pkg::sample_t                   left_out,
  output sfe_pkg::sample_t                   right_out,
  output logic [sfe_pkg::FQ_CNT_W-1:0]       count
);

  sfe_pkg::frame_t entries [sfe_pkg::FQ_DEPTH];
  logic [sfe_pkg::FQ_AW-1:0] wr_ptr;
  logic [sfe_pkg::FQ_AW-1:0] rd_ptr;
  logic pop;

  assign out_valid = (count != '0);
  assign pop = out_valid && !out_stall;
  assign left_out = entries[rd_ptr].left;
  assign right_out = entries[rd_ptr].right;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{left: push_left, right: push_right};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sfe_checker.sv -----
// sfe_checker: port-level checks on the stereo feedback echo unit and the
// bind that attaches them to the top level; depends on sfe_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfe_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire sfe_pkg::sample_t left_out,
  input wire sfe_pkg::sample_t right_out
);

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_stall |=> out_valid && $stable(left_out) && $stable(right_out))
    else $error("stalled output beat changed");

  // input never stalls while nothing waits at the output
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
      !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // an accepted beat is offered once stage 1 has pushed it into the queue
  a_latency: assert property (@(posedge clk) disable iff (rst)
      in_valid && !in_stall |-> ##2 out_valid)
    else $error("accepted beat not offered in time");

endmodule

bind stereo_feedback_echo_unit sfe_checker u_sfe_checker (.*);

`default_nettype wire
